// ===== rtl/core/ntpts_pkg.sv =====
// Package for the NTP timestamp parser: packet offsets, time constants,
// status codes and the job struct handed to the time calculation.
// No dependencies.
package ntpts_pkg;

    // Packet layout
    localparam int unsigned MIN_PACKET_BYTES = 48;
    localparam int unsigned SECONDS_FIRST    = 40;
    localparam int unsigned FRACTION_FIRST   = 44;
    localparam int unsigned COUNT_W          = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [7:0]  LEAP_MASK        = 8'b1100_0000;

    // Time conversion
    localparam int unsigned TIME_W   = 61;
    localparam int unsigned DIFF_W   = 31;   // seconds past the Unix epoch
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NS_W     = 30;
    localparam int unsigned FRAC_NS_W = 30;
    localparam logic [WORD_W-1:0] EPOCH_OFFSET_S = 32'd2208988800;
    localparam logic [NS_W-1:0]   NS_PER_S       = 30'd1000000000;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_LEAP      = 2'd2,
        ST_PRE_EPOCH = 2'd3
    } t_status;

    // One finished packet, ready for conversion
    typedef struct packed {
        logic [DIFF_W-1:0] diff;     // zero on error
        logic [WORD_W-1:0] frac;     // zero on error
        t_status           status;
    } t_calc_job;

endpackage

// ===== rtl/core/ntpts_if.sv =====
// Valid/ready channel interfaces for the NTP timestamp parser:
// the packet byte stream and the result stream. No dependencies.
interface ntpts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ntpts_result_if;
    logic        valid;
    logic        ready;
    logic [60:0] unix_time_ns;
    logic [1:0]  status;

    modport source (output valid, output unix_time_ns, output status, input ready);
    modport sink   (input valid, input unix_time_ns, input status, output ready);
endinterface

// ===== rtl/core/ntpts_time_calc.sv =====
// Two-stage conversion of a finished packet to Unix nanoseconds:
// product registers, then the final add into the output register.
// Depends on ntpts_pkg and ntpts_result_if.
module ntpts_time_calc
    import ntpts_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_calc_job             i_job,
    output logic                  o_job_ready,
    ntpts_result_if.source        o_result
);

    logic                     r_p_v;
    logic [TIME_W-1:0]        r_p_sec;
    logic [FRAC_NS_W-1:0]     r_p_frac;
    t_status                  r_p_status;

    logic                     r_o_v;
    logic [TIME_W-1:0]        r_o_time;
    t_status                  r_o_status;

    logic                     o_load;
    logic                     p_load;
    logic [2*WORD_W-3:0]      w_frac_prod;   // 62 bits

    // Stage hand-off: a stage loads when empty or when it empties this cycle
    assign o_load      = !r_o_v || o_result.ready;
    assign p_load      = !r_p_v || o_load;
    assign o_job_ready = p_load;

    assign w_frac_prod = (2*WORD_W-2)'(i_job.frac) * NS_PER_S;

    // Control valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (p_load) r_p_v <= i_job_valid;
            if (o_load) r_o_v <= r_p_v;
        end
    end

    // Product stage: whole seconds and fraction scaled to nanoseconds
    always_ff @(posedge i_clk) begin
        if (p_load && i_job_valid) begin
            r_p_sec    <= TIME_W'(i_job.diff) * NS_PER_S;
            r_p_frac   <= w_frac_prod[2*WORD_W-3:WORD_W];
            r_p_status <= i_job.status;
        end
    end

    // Output stage: final sum
    always_ff @(posedge i_clk) begin
        if (o_load && r_p_v) begin
            r_o_time   <= r_p_sec + TIME_W'(r_p_frac);
            r_o_status <= r_p_status;
        end
    end

    assign o_result.valid        = r_o_v;
    assign o_result.unix_time_ns = r_o_time;
    assign o_result.status       = r_o_status;

endmodule

// ===== rtl/core/ntp_timestamp_parser.sv =====
// NTP reply parser: transmit timestamp to Unix nanoseconds.
// Throughput: one packet byte per cycle, back to back, across packet boundaries,
// while the output does not stall. After the last byte's transaction the result
// passes the job, product and output registers; output stalls back up.
// Reset (synchronous, active low) empties the pipeline and restarts packet count.
// Depends on ntpts_pkg, ntpts_if and ntpts_time_calc.
module ntp_timestamp_parser
    import ntpts_pkg::*;
#(
    parameter int unsigned MIN_BYTES = MIN_PACKET_BYTES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ntpts_byte_if.sink     i_byte,
    ntpts_result_if.source o_result
);

    // Per-packet state
    logic [COUNT_W-1:0] r_count;
    logic               r_leap;
    logic [WORD_W-1:0]  r_sec;
    logic [WORD_W-1:0]  r_frac;

    logic [COUNT_W-1:0] n_count;
    logic               n_leap;
    logic [WORD_W-1:0]  n_sec;
    logic [WORD_W-1:0]  n_frac;

    // Job register
    logic               r_j_v;
    t_calc_job          r_j;
    t_calc_job          n_j;

    logic               job_ready;
    logic               accept;
    logic [DIFF_W-1:0]  sec_diff;

    assign i_byte.ready = !r_j_v || job_ready;
    assign accept       = i_byte.valid && i_byte.ready;

    // Capture the byte by position; count saturates
    always_comb begin
        n_leap  = r_leap;
        n_sec   = r_sec;
        n_frac  = r_frac;
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        if (r_count == '0) begin
            n_leap = (i_byte.data_byte & LEAP_MASK) == LEAP_MASK;
        end else if (r_count inside {[SECONDS_FIRST:SECONDS_FIRST+3]}) begin
            n_sec = {r_sec[WORD_W-9:0], i_byte.data_byte};
        end else if (r_count inside {[FRACTION_FIRST:FRACTION_FIRST+3]}) begin
            n_frac = {r_frac[WORD_W-9:0], i_byte.data_byte};
        end
    end

    // Checks in priority order; errors zero the operands
    assign sec_diff = DIFF_W'(n_sec - EPOCH_OFFSET_S);

    always_comb begin
        n_j.diff   = '0;
        n_j.frac   = '0;
        if (n_count < COUNT_W'(MIN_BYTES)) begin
            n_j.status = ST_SHORT;
        end else if (n_leap) begin
            n_j.status = ST_LEAP;
        end else if (n_sec <= EPOCH_OFFSET_S) begin
            n_j.status = ST_PRE_EPOCH;
        end else begin
            n_j.status = ST_OK;
            n_j.diff   = sec_diff;
            n_j.frac   = n_frac;
        end
    end

    // Packet control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_leap  <= 1'b0;
            r_j_v   <= 1'b0;
        end else begin
            if (accept && i_byte.last_byte) begin
                r_j_v <= 1'b1;
            end else if (job_ready) begin
                r_j_v <= 1'b0;
            end
            if (accept) begin
                if (i_byte.last_byte) begin
                    r_count <= '0;
                    r_leap  <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_leap  <= n_leap;
                end
            end
        end
    end

    // Timestamp words and job payload; fully rewritten before use
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sec  <= n_sec;
            r_frac <= n_frac;
            if (i_byte.last_byte) r_j <= n_j;
        end
    end

    ntpts_time_calc u_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_j_v),
        .i_job       (r_j),
        .o_job_ready (job_ready),
        .o_result    (o_result)
    );

endmodule
